>>> rtl/efcs_pkg.sv
// Shared types and fixed widths for the earliest-free counter scheduler.
// Depends on nothing; every other file of the block imports it.
package efcs_pkg;

  localparam int SVC_W  = 16;
  localparam int PAY_W  = 16;
  localparam int TIME_W = 32;
  localparam int SIDX_W = 7;
  localparam int CFG_W  = 7;
  localparam logic [TIME_W-1:0] SAT_MAX = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic rd_parent;
    logic up_step;
    logic rd_root;
    logic load_root;
    logic pay_upd;
    logic rd_child;
    logic dn_step;
    logic write_e;
    logic done;
  } efcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic filling;
    logic at_root;
    logic leaf;
    logic up_move;
    logic dn_move;
    logic out_free;
  } efcs_sts_t;

endpackage

>>> rtl/efcs_job_if.sv
// Request channel carrying one job: service time and payment.
// Depends on efcs_pkg for the field widths.
interface efcs_job_if import efcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SVC_W-1:0] service_time;
  logic [PAY_W-1:0] payment;

  modport source (output valid, service_time, payment, input ready);
  modport sink (input valid, service_time, payment, output ready);
endinterface

>>> rtl/efcs_res_if.sv
// Result channel carrying one scheduling decision per request.
// Depends on efcs_pkg for the field widths.
interface efcs_res_if import efcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIDX_W-1:0] server_index;
  logic [TIME_W-1:0] finish_time;
  logic [TIME_W-1:0] server_total;
  logic [TIME_W-1:0] latest_finish;

  modport source (output valid, server_index, finish_time, server_total, latest_finish,
                  input ready);
  modport sink (input valid, server_index, finish_time, server_total, latest_finish,
                output ready);
endinterface

>>> rtl/efcs_ctrl.sv
// Sequencing state machine of the scheduler.
// Depends on efcs_pkg for the command and status structs.
module efcs_ctrl import efcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  efcs_sts_t sts,
  output efcs_cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_TEST = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_RD_ROOT = 4'd3;
  localparam logic [3:0] S_LOAD    = 4'd4;
  localparam logic [3:0] S_PAY     = 4'd5;
  localparam logic [3:0] S_DN_TEST = 4'd6;
  localparam logic [3:0] S_DN_CMP  = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands for each step of a request.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.filling ? S_UP_TEST : S_RD_ROOT;
        end
      end
      S_UP_TEST: begin
        if (sts.at_root) begin
          cmd.write_e = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_move) begin
          cmd.up_step = 1'b1;
          state_nxt   = S_UP_TEST;
        end else begin
          cmd.write_e = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_RD_ROOT: begin
        cmd.rd_root = 1'b1;
        state_nxt   = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_root = 1'b1;
        state_nxt     = S_PAY;
      end
      S_PAY: begin
        cmd.pay_upd = 1'b1;
        state_nxt   = S_DN_TEST;
      end
      S_DN_TEST: begin
        if (sts.leaf) begin
          cmd.write_e = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_child = 1'b1;
          state_nxt    = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts.dn_move) begin
          cmd.dn_step = 1'b1;
          state_nxt   = S_DN_TEST;
        end else begin
          cmd.write_e = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A request is only taken while nothing is in flight.
  a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_UP_TEST) || (state_r == S_RD_ROOT))
    else $error("request taken from a busy sequencer");
  // Completion always returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |=> in_ready)
    else $error("sequencer did not return to idle");
  // The heap element is placed exactly once, on the way into the completion step.
  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_e |=> state_r == S_DONE)
    else $error("element written outside the final step");

endmodule

>>> rtl/efcs_dp.sv
// Datapath of the scheduler: heap and payment memories, sift registers, result register.
// Depends on efcs_pkg for widths and the command and status structs.
module efcs_dp import efcs_pkg::*; #(
  parameter int MAX_SERVERS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic [SVC_W-1:0]  in_service_time,
  input  logic [PAY_W-1:0]  in_payment,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [SIDX_W-1:0] out_server_index,
  output logic [TIME_W-1:0] out_finish_time,
  output logic [TIME_W-1:0] out_server_total,
  output logic [TIME_W-1:0] out_latest_finish,
  input  efcs_cmd_t         cmd,
  output efcs_sts_t         sts
);

  localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CW = $clog2(MAX_SERVERS + 1);
  localparam int HD = 2 ** AW;
  localparam int HW = TIME_W + AW;

  logic [CFG_W-1:0]  cfg_r;
  logic [CW-1:0]     jobs_r;
  logic [TIME_W-1:0] latest_r;
  logic [SVC_W-1:0]  svc_r;
  logic [PAY_W-1:0]  pay_r;
  logic [TIME_W-1:0] e_t_r;
  logic [AW-1:0]     e_idx_r;
  logic [AW-1:0]     pos_r;
  logic [TIME_W-1:0] total_r;
  logic              out_valid_r;
  logic [SIDX_W-1:0] out_idx_r;
  logic [TIME_W-1:0] out_fin_r, out_tot_r, out_lat_r;

  logic [HW-1:0]     heap_mem [HD];
  logic [TIME_W-1:0] pay_mem [HD];
  logic [HW-1:0]     rd_a_q, rd_b_q;
  logic [TIME_W-1:0] pay_q;

  logic [CW-1:0]     n_eff;
  logic [AW-1:0]     parent;
  logic [AW+1:0]     c1, c2, n_ext;
  logic [AW-1:0]     addr_a, addr_b, best_addr, h_waddr;
  logic              use_c2, h_we;
  logic [HW-1:0]     best, e_ent, h_wdata;
  logic [TIME_W:0]   sum_t, sum_p;
  logic [TIME_W-1:0] lat_new;
  logic [AW:0]       k1;

  // Heap order: earlier finish first, lower server index on ties.
  function automatic logic before_f(input logic [HW-1:0] a, input logic [HW-1:0] b);
    logic [TIME_W-1:0] at, bt;
    at = a[HW-1:AW];
    bt = b[HW-1:AW];
    return (at < bt) || ((at == bt) && (a[AW-1:0] < b[AW-1:0]));
  endfunction

  // Effective number of servers.
  always_comb begin
    if (cfg_r == '0) begin
      n_eff = CW'(1);
    end else if (int'(cfg_r) > MAX_SERVERS) begin
      n_eff = CW'(MAX_SERVERS);
    end else begin
      n_eff = CW'(cfg_r);
    end
  end

  // Tree addressing around the current position.
  assign parent = (pos_r - AW'(1)) >> 1;
  assign c1     = {1'b0, pos_r, 1'b1};
  assign c2     = c1 + (AW+2)'(1);
  assign n_ext  = (AW+2)'(n_eff);
  assign e_ent  = {e_t_r, e_idx_r};

  assign addr_a = cmd.rd_root ? '0 : (cmd.rd_parent ? parent : c1[AW-1:0]);
  assign addr_b = c2[AW-1:0];

  // Smaller of the two children.
  assign use_c2    = (c2 < n_ext) && before_f(rd_b_q, rd_a_q);
  assign best      = use_c2 ? rd_b_q : rd_a_q;
  assign best_addr = use_c2 ? c2[AW-1:0] : c1[AW-1:0];

  // Saturating sums.
  assign sum_t   = {1'b0, rd_a_q[HW-1:AW]} + {{(TIME_W-SVC_W+1){1'b0}}, svc_r};
  assign sum_p   = {1'b0, pay_q} + {{(TIME_W-PAY_W+1){1'b0}}, pay_r};
  assign lat_new = (e_t_r > latest_r) ? e_t_r : latest_r;
  assign k1      = {1'b0, e_idx_r} + (AW+1)'(1);

  // Heap write port.
  assign h_we    = cmd.write_e | cmd.up_step | cmd.dn_step;
  assign h_waddr = pos_r;
  assign h_wdata = cmd.write_e ? e_ent : (cmd.up_step ? rd_a_q : best);

  // Status to the controller.
  assign sts.filling  = (jobs_r < n_eff);
  assign sts.at_root  = (pos_r == '0);
  assign sts.leaf     = !(c1 < n_ext);
  assign sts.up_move  = before_f(e_ent, rd_a_q);
  assign sts.dn_move  = before_f(best, e_ent);
  assign sts.out_free = !out_valid_r || out_ready;

  // Heap memory.
  always_ff @(posedge clk) begin
    if (h_we) begin
      heap_mem[h_waddr] <= h_wdata;
    end
    rd_a_q <= heap_mem[addr_a];
    rd_b_q <= heap_mem[addr_b];
  end

  // Payment memory.
  always_ff @(posedge clk) begin
    if (cmd.capture && sts.filling) begin
      pay_mem[AW'(jobs_r)] <= {{(TIME_W-PAY_W){1'b0}}, in_payment};
    end else if (cmd.pay_upd) begin
      pay_mem[e_idx_r] <= sum_p[TIME_W] ? SAT_MAX : sum_p[TIME_W-1:0];
    end
    pay_q <= pay_mem[rd_a_q[AW-1:0]];
  end

  // Working registers of the request in flight.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      svc_r <= in_service_time;
      pay_r <= in_payment;
      if (sts.filling) begin
        e_t_r   <= {{(TIME_W-SVC_W){1'b0}}, in_service_time};
        e_idx_r <= AW'(jobs_r);
        pos_r   <= AW'(jobs_r);
        total_r <= {{(TIME_W-PAY_W){1'b0}}, in_payment};
      end
    end
    if (cmd.load_root) begin
      e_t_r   <= sum_t[TIME_W] ? SAT_MAX : sum_t[TIME_W-1:0];
      e_idx_r <= rd_a_q[AW-1:0];
      pos_r   <= '0;
    end
    if (cmd.pay_upd) begin
      total_r <= sum_p[TIME_W] ? SAT_MAX : sum_p[TIME_W-1:0];
    end
    if (cmd.up_step) begin
      pos_r <= parent;
    end
    if (cmd.dn_step) begin
      pos_r <= best_addr;
    end
  end

  // Control state: register, job count, running maximum, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_W'(1);
      jobs_r      <= '0;
      latest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r    <= cfg_wdata;
        jobs_r   <= '0;
        latest_r <= '0;
      end else if (cmd.done) begin
        latest_r <= lat_new;
        if (sts.filling) begin
          jobs_r <= jobs_r + CW'(1);
        end
      end
      if (cmd.done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.done) begin
      out_idx_r <= SIDX_W'(k1);
      out_fin_r <= e_t_r;
      out_tot_r <= total_r;
      out_lat_r <= lat_new;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_server_index  = out_idx_r;
  assign out_finish_time   = out_fin_r;
  assign out_server_total  = out_tot_r;
  assign out_latest_finish = out_lat_r;

  // The job count never passes the number of servers.
  a_jobs_range: assert property (@(posedge clk) disable iff (!rst_n)
    jobs_r <= n_eff)
    else $error("job count beyond server count");
  // The running maximum only grows between configuration writes.
  a_latest_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> latest_r >= $past(latest_r))
    else $error("latest finish decreased");
  // A completed request is always presented.
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |=> out_valid_r)
    else $error("completed request not presented");

endmodule

>>> rtl/earliest_free_counter_scheduler.sv
// Top level of the earliest-free counter scheduler.
// Depends on efcs_pkg, efcs_job_if, efcs_res_if, efcs_ctrl and efcs_dp.

// Each request (service time, payment) is assigned to a server. The first N
// requests after reset or a write of cfg_wdata go to servers 1..N; later ones
// go to the server with the earliest finish time (lowest index on ties), kept
// in a binary min-heap in block memory. Only one request is in flight. The
// first N are placed at the next free leaf and climb toward the root. Later
// ones read the root, add the service time to its finish time and the
// payment to that server's total, then sift the entry down toward a leaf.
// Each heap level costs one memory read and one compare through the single
// heap write port. A finished result waits in an output register while the
// next request is taken; a request that finishes while that register is
// still full waits for it to be taken. Writing the server count clears the
// job count and the latest finish time at once.
module earliest_free_counter_scheduler import efcs_pkg::*; #(
  parameter int MAX_SERVERS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  efcs_job_if.sink         in_job,
  efcs_res_if.source       out_res
);

  efcs_cmd_t cmd;
  efcs_sts_t sts;

  // Sequencer.
  efcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_job.valid),
    .in_ready (in_job.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  efcs_dp #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_service_time   (in_job.service_time),
    .in_payment        (in_job.payment),
    .out_ready         (out_res.ready),
    .out_valid         (out_res.valid),
    .out_server_index  (out_res.server_index),
    .out_finish_time   (out_res.finish_time),
    .out_server_total  (out_res.server_total),
    .out_latest_finish (out_res.latest_finish),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
